### rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/htd_pkg.sv
// shared types and constants of the huffman tree decoder
`timescale 1ns / 1ps
`default_nettype none

package htd_pkg;

    localparam int NODES    = 512;
    localparam int ADDR_W   = $clog2(NODES);
    localparam int IDX_W    = 9;
    localparam int SYM_W    = 8;
    localparam int BYTE_W   = 8;
    localparam int CNT_W    = 4;
    localparam int NODE_W   = 2 * IDX_W + 1 + SYM_W;

    localparam logic [CNT_W-1:0] MAX_BITS = 4'd8;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_DECODE = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
        logic             leaf;
        logic [SYM_W-1:0] sym;
    } t_node;

endpackage

`default_nettype wire

### rtl/htd_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none

module htd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### rtl/huffman_tree_decoder.sv
// top level: huffman decoder walking a code tree held in a node ram
//
// Input channel (i_in_valid / o_in_stall) carries two kinds of request.
// A node write (req_type 0) stores one tree node and returns the cursor to
// the root and produces no result. A decode request (req_type 1) brings
// one code byte, consumed msb first, bit_count bits but at most 8.
// The cursor into the tree survives across bytes, so codes may span bytes.
// Output channel (o_out_valid / i_out_stall) carries one result per decoded
// symbol, or a single error result when a bit is taken on a leaf node;
// o_last marks the final result of a byte.
// An error ends the byte at once. Each bit costs one dependent read of the
// node ram, and the root entry is fetched again after every symbol. The
// next request is accepted once the byte is finished and its last result
// sits in the output register.
// A stalled receiver holds the output register; a second result then
// waits in a one-entry holding register and the tree walk pauses.
// Reset (synchronous, active low) clears the root register and cursor to 0
// and empties the output; the node ram is not cleared and must be loaded.

`timescale 1ns / 1ps
`default_nettype none

module huffman_tree_decoder (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [htd_pkg::IDX_W-1:0]   i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_req_type,
    input  wire logic [htd_pkg::IDX_W-1:0]   i_node_index,
    input  wire logic [htd_pkg::IDX_W-1:0]   i_left_child,
    input  wire logic [htd_pkg::IDX_W-1:0]   i_right_child,
    input  wire logic                        i_is_leaf,
    input  wire logic [htd_pkg::SYM_W-1:0]   i_leaf_symbol,
    input  wire logic [htd_pkg::BYTE_W-1:0]  i_code_byte,
    input  wire logic [htd_pkg::CNT_W-1:0]   i_bit_count,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [htd_pkg::SYM_W-1:0]   o_symbol,
    output logic                             o_error,
    output logic                             o_last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;

    logic [htd_pkg::IDX_W-1:0]  r_root, n_root;
    logic [htd_pkg::IDX_W-1:0]  r_cursor, n_cursor;
    logic                       r_arrived, n_arrived;
    logic [htd_pkg::BYTE_W-1:0] r_byte, n_byte;
    logic [htd_pkg::CNT_W-1:0]  r_bits, n_bits;
    logic                       r_rd_oob, n_rd_oob;

    logic                       r_pend_valid, n_pend_valid;
    logic [htd_pkg::SYM_W-1:0]  r_pend_sym, n_pend_sym;
    logic                       r_pend_err, n_pend_err;

    logic                       r_out_valid, n_out_valid;
    logic [htd_pkg::SYM_W-1:0]  r_out_sym, n_out_sym;
    logic                       r_out_err, n_out_err;
    logic                       r_out_last, n_out_last;

    logic                              ram_wr_en;
    logic [htd_pkg::NODE_W-1:0]        ram_rd_data;
    htd_pkg::t_node                    wr_node;
    htd_pkg::t_node                    cur;
    logic                              in_accept;
    logic                              out_free;
    logic                              can_emit;
    logic                              emit;
    logic [htd_pkg::SYM_W-1:0]         emit_sym;
    logic                              emit_err;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign can_emit  = !r_pend_valid || out_free;
    // entries beyond the table read as zero
    assign cur       = r_rd_oob ? '0 : htd_pkg::t_node'(ram_rd_data);

    assign wr_node.left  = i_left_child;
    assign wr_node.right = i_right_child;
    assign wr_node.leaf  = i_is_leaf;
    assign wr_node.sym   = i_leaf_symbol;

    htd_ram #(
        .WIDTH (htd_pkg::NODE_W),
        .DEPTH (htd_pkg::NODES)
    ) u_node_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (htd_pkg::ADDR_W'(i_node_index)),
        .i_wr_data (wr_node),
        .i_rd_addr (htd_pkg::ADDR_W'(n_cursor)),
        .o_rd_data (ram_rd_data)
    );

    always_comb begin
        n_state      = r_state;
        n_root       = r_root;
        n_cursor     = r_cursor;
        n_arrived    = r_arrived;
        n_byte       = r_byte;
        n_bits       = r_bits;
        n_pend_valid = r_pend_valid;
        n_pend_sym   = r_pend_sym;
        n_pend_err   = r_pend_err;
        n_out_valid  = r_out_valid;
        n_out_sym    = r_out_sym;
        n_out_err    = r_out_err;
        n_out_last   = r_out_last;
        ram_wr_en    = 1'b0;
        emit         = 1'b0;
        emit_sym     = '0;
        emit_err     = 1'b0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (i_cfg_we) begin
            n_root   = i_cfg_data;
            n_cursor = i_cfg_data;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    if (i_req_type == htd_pkg::REQ_WRITE) begin
                        ram_wr_en = (32'(i_node_index) < htd_pkg::NODES);
                        n_cursor  = r_root;
                    end else begin
                        n_byte    = i_code_byte;
                        n_bits    = (i_bit_count > htd_pkg::MAX_BITS) ?
                                    htd_pkg::MAX_BITS : i_bit_count;
                        n_arrived = 1'b0;
                        n_state   = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                // ram data holds the entry at the cursor in this state
                if (r_arrived && cur.leaf) begin
                    if (can_emit) begin
                        emit      = 1'b1;
                        emit_sym  = cur.sym;
                        n_cursor  = r_root;
                        n_arrived = 1'b0;
                        if (r_bits == '0) begin
                            n_state = ST_FINISH;
                        end
                    end
                end else if (r_bits == '0) begin
                    n_arrived = 1'b0;
                    n_state   = ST_FINISH;
                end else if (cur.leaf) begin
                    // bit taken on a childless node
                    if (can_emit) begin
                        emit      = 1'b1;
                        emit_err  = 1'b1;
                        n_cursor  = r_root;
                        n_arrived = 1'b0;
                        n_bits    = '0;
                        n_state   = ST_FINISH;
                    end
                end else begin
                    n_cursor  = r_byte[htd_pkg::BYTE_W-1] ? cur.right : cur.left;
                    n_byte    = {r_byte[htd_pkg::BYTE_W-2:0], 1'b0};
                    n_bits    = r_bits - 4'd1;
                    n_arrived = 1'b1;
                end
            end
            ST_FINISH: begin
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_sym    = r_pend_sym;
                    n_out_err    = r_pend_err;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // a new result pushes the held one out; last is known only at the end
        if (emit) begin
            if (r_pend_valid) begin
                n_out_valid = 1'b1;
                n_out_sym   = r_pend_sym;
                n_out_err   = r_pend_err;
                n_out_last  = 1'b0;
            end
            n_pend_valid = 1'b1;
            n_pend_sym   = emit_sym;
            n_pend_err   = emit_err;
        end

        n_rd_oob = (32'(n_cursor) >= htd_pkg::NODES);
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_bits     <= n_bits;
        r_rd_oob   <= n_rd_oob;
        r_pend_sym <= n_pend_sym;
        r_pend_err <= n_pend_err;
        r_out_sym  <= n_out_sym;
        r_out_err  <= n_out_err;
        r_out_last <= n_out_last;
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_root       <= '0;
            r_cursor     <= '0;
            r_arrived    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_root       <= n_root;
            r_cursor     <= n_cursor;
            r_arrived    <= n_arrived;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_symbol    = r_out_sym;
    assign o_error     = r_out_err;
    assign o_last      = r_out_last;

endmodule

`default_nettype wire

### rtl/htd_checker.sv
// port-level checker for the huffman tree decoder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module htd_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        o_in_stall,
    input  wire logic                        i_req_type,
    input  wire logic                        o_out_valid,
    input  wire logic                        i_out_stall,
    input  wire logic [htd_pkg::SYM_W-1:0]   o_symbol,
    input  wire logic                        o_error,
    input  wire logic                        o_last
);

    // a stalled result stays put
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_symbol) && $stable(o_error) && $stable(o_last))

    // an error result carries symbol zero and ends its byte
    `ASSERT_IMPLIES(a_err_form, i_clk, i_rst_n, o_out_valid && o_error, (o_symbol == '0) && o_last)

    // a decode request moves the block out of idle, so the input stalls after it is taken
    `ASSERT_NEXT(a_dec_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_req_type == htd_pkg::REQ_DECODE), o_in_stall)

    // node writes complete in the cycle they are taken
    `ASSERT_NEXT(a_wr_quick, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_req_type == htd_pkg::REQ_WRITE), !o_in_stall)

endmodule

bind huffman_tree_decoder htd_checker u_htd_checker (.*);

`default_nettype wire

### tb/tb_huffman_tree_decoder.sv
// testbench for the huffman tree decoder: tree loads, byte decodes, result checks
`timescale 1ns / 1ps

module tb_huffman_tree_decoder;

    localparam int SETTLE      = 40;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                       req_type;
        logic [htd_pkg::IDX_W-1:0]  node_index;
        logic [htd_pkg::IDX_W-1:0]  left_child;
        logic [htd_pkg::IDX_W-1:0]  right_child;
        logic                       is_leaf;
        logic [htd_pkg::SYM_W-1:0]  leaf_symbol;
        logic [htd_pkg::BYTE_W-1:0] code_byte;
        logic [htd_pkg::CNT_W-1:0]  bit_count;
    } t_request;

    typedef struct packed {
        logic [htd_pkg::SYM_W-1:0] symbol;
        logic                      error;
        logic                      last;
    } t_result;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [htd_pkg::IDX_W-1:0]  cfg_data  = '0;
    logic                       req_valid = 1'b0;
    t_request                   req       = '0;
    logic                       in_stall;
    logic                       res_valid;
    logic                       res_stall = 1'b0;
    logic [htd_pkg::SYM_W-1:0]  res_symbol;
    logic                       res_error;
    logic                       res_last;

    // stimulus side: requests not yet offered and the nodes known to be loaded
    t_request    requests_to_send [$];
    bit          node_loaded [htd_pkg::NODES];
    int          loaded_list [$];
    int          items_queued = 0;
    int          cur_root     = 0;
    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    int          phase_idx    = 0;

    // predictor side
    htd_pkg::t_node            tree_ram [htd_pkg::NODES];
    logic [htd_pkg::IDX_W-1:0] root_reg = '0;
    logic [htd_pkg::IDX_W-1:0] walk_pos = '0;
    t_result                   symbols_due [$];
    int                        bad_results = 0;

    int          hold_left   = 0;
    bit          hold_done   = 1'b0;
    int unsigned cycle_count = 0;

    huffman_tree_decoder i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (req_valid),
        .o_in_stall    (in_stall),
        .i_req_type    (req.req_type),
        .i_node_index  (req.node_index),
        .i_left_child  (req.left_child),
        .i_right_child (req.right_child),
        .i_is_leaf     (req.is_leaf),
        .i_leaf_symbol (req.leaf_symbol),
        .i_code_byte   (req.code_byte),
        .i_bit_count   (req.bit_count),
        .o_out_valid   (res_valid),
        .i_out_stall   (res_stall),
        .o_symbol      (res_symbol),
        .o_error       (res_error),
        .o_last        (res_last)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic void decode_request(t_request r);
        htd_pkg::t_node            here;
        htd_pkg::t_node            ahead;
        logic [htd_pkg::IDX_W-1:0] next_idx;
        t_result                   held;
        bit                        have_held;
        bit                        fault;
        int                        nbits;
        held      = '0;
        have_held = 1'b0;
        if (r.req_type == htd_pkg::REQ_WRITE) begin
            tree_ram[r.node_index] = {r.left_child, r.right_child, r.is_leaf, r.leaf_symbol};
            walk_pos = root_reg;
            return;
        end
        nbits = (r.bit_count > htd_pkg::MAX_BITS) ? int'(htd_pkg::MAX_BITS) :
                                                    int'(r.bit_count);
        for (int i = 0; i < nbits; i++) begin
            here     = tree_ram[walk_pos];
            fault    = here.leaf;
            next_idx = r.code_byte[htd_pkg::BYTE_W-1-i] ? here.right : here.left;
            ahead    = tree_ram[next_idx];
            if (fault || ahead.leaf) begin
                if (have_held)
                    symbols_due.push_back(held);
                held.symbol = fault ? {htd_pkg::SYM_W{1'b0}} : ahead.sym;
                held.error  = fault;
                held.last   = 1'b0;
                have_held   = 1'b1;
                walk_pos    = root_reg;
                // a walk that starts on a leaf drops the rest of the byte
                if (fault)
                    break;
            end else begin
                walk_pos = next_idx;
            end
        end
        if (have_held) begin
            held.last = 1'b1;
            symbols_due.push_back(held);
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void queue_node(int idx, int lft, int rgt, bit leaf, int sym);
        t_request    r;
        logic [63:0] filler;
        filler        = {$urandom(), $urandom()};
        r             = filler[$bits(t_request)-1:0];
        r.req_type    = htd_pkg::REQ_WRITE;
        r.node_index  = htd_pkg::IDX_W'(idx);
        r.left_child  = htd_pkg::IDX_W'(lft);
        r.right_child = htd_pkg::IDX_W'(rgt);
        r.is_leaf     = leaf;
        r.leaf_symbol = htd_pkg::SYM_W'(sym);
        requests_to_send.push_back(r);
        items_queued++;
        if (!node_loaded[idx]) begin
            node_loaded[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
    endfunction

    function automatic void queue_decode(int code, int count);
        t_request    r;
        logic [63:0] filler;
        filler      = {$urandom(), $urandom()};
        r           = filler[$bits(t_request)-1:0];
        r.req_type  = htd_pkg::REQ_DECODE;
        r.code_byte = htd_pkg::BYTE_W'(code);
        r.bit_count = htd_pkg::CNT_W'(count);
        requests_to_send.push_back(r);
        items_queued++;
    endfunction

    function automatic int pick_loaded();
        return loaded_list[$urandom_range(loaded_list.size() - 1)];
    endfunction

    function automatic int index_off_root(int top);
        int idx;
        do idx = $urandom_range(htd_pkg::NODES - 1);
        while (idx == top);
        return idx;
    endfunction

    function automatic int pick_bit_count();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return 8;
        if (roll < 92)
            return $urandom_range(7, 1);
        if (roll < 96)
            return 0;
        return $urandom_range(15, 9);
    endfunction

    // children are always written before their parent, so a walk never
    // reaches an entry that was not loaded
    function automatic void build_tree(int top, int leaves);
        int pool [$];
        int pos;
        int a;
        int b;
        int idx;
        if (leaves == 1) begin
            queue_node(top, $urandom_range(htd_pkg::NODES - 1),
                       $urandom_range(htd_pkg::NODES - 1), 1'b1, $urandom_range(255));
            return;
        end
        for (int k = 0; k < leaves; k++) begin
            idx = index_off_root(top);
            queue_node(idx, $urandom_range(htd_pkg::NODES - 1),
                       $urandom_range(htd_pkg::NODES - 1), 1'b1, $urandom_range(255));
            pool.push_back(idx);
        end
        while (pool.size() > 2) begin
            pos = $urandom_range(pool.size() - 1);
            a   = pool[pos];
            pool.delete(pos);
            pos = $urandom_range(pool.size() - 1);
            b   = pool[pos];
            pool.delete(pos);
            idx = index_off_root(top);
            queue_node(idx, a, b, 1'b0, $urandom_range(255));
            pool.push_back(idx);
        end
        queue_node(top, pool[0], pool[1], 1'b0, $urandom_range(255));
    endfunction

    function automatic void queue_session();
        build_tree(cur_root, ($urandom_range(14) == 0) ? 1 : $urandom_range(12, 2));
        repeat ($urandom_range(8, 2))
            queue_decode($urandom_range(255), pick_bit_count());
    endfunction

    function automatic void queue_random(int target);
        int start;
        int roll;
        start = items_queued;
        queue_session();
        while (items_queued - start < target) begin
            roll = $urandom_range(99);
            if (roll < 55) begin
                queue_session();
            end else if (roll < 85) begin
                repeat ($urandom_range(6, 1))
                    queue_decode($urandom_range(255), pick_bit_count());
            end else if ($urandom_range(1) == 1) begin
                queue_node($urandom_range(htd_pkg::NODES - 1),
                           $urandom_range(htd_pkg::NODES - 1),
                           $urandom_range(htd_pkg::NODES - 1), 1'b1, $urandom_range(255));
            end else begin
                queue_node($urandom_range(htd_pkg::NODES - 1), pick_loaded(), pick_loaded(),
                           1'b0, $urandom_range(255));
            end
        end
    endfunction

    task automatic wait_drained();
        do @(posedge clk);
        while (requests_to_send.size() != 0 || req_valid || symbols_due.size() != 0);
    endtask

    task automatic load_root(int value, int unsigned tx_pct, int unsigned rx_pct, int phase);
        // a request with no result may still be walking the tree
        repeat (SETTLE) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= htd_pkg::IDX_W'(value);
        cur_root  = value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        tx_idle_pct <= tx_pct;
        rx_idle_pct <= rx_pct;
        phase_idx   <= phase;
    endtask

    initial begin
        repeat (8) @(posedge clk);
        rst_n       <= 1'b1;
        tx_idle_pct <= 27;
        rx_idle_pct <= 71;
        phase_idx   <= 0;

        // two leaves, at the top index and at index 1, under root 0
        queue_node(htd_pkg::NODES - 1, htd_pkg::NODES - 1, 0, 1'b1, 8'hFF);
        queue_node(1, 0, htd_pkg::NODES - 1, 1'b1, 8'h00);
        queue_node(0, htd_pkg::NODES - 1, 1, 1'b0, 8'hA5);
        queue_decode(8'h00, 8);
        queue_decode(8'hFF, 8);
        queue_decode(8'h5A, 1);
        queue_decode(8'h5A, 0);
        queue_decode(8'hC3, 15);
        queue_decode(8'h96, 9);
        // single-symbol tree: walk starts on a leaf
        queue_node(0, 0, 0, 1'b1, 8'h77);
        queue_decode(8'hFF, 8);
        queue_decode(8'h00, 0);
        // root that loops on itself, no code word ever completes
        queue_node(0, 0, 0, 1'b0, 8'h00);
        queue_decode(8'hA5, 8);
        // deeper tree, short counts so code words span bytes
        build_tree(0, 4);
        queue_decode($urandom_range(255), 3);
        queue_decode($urandom_range(255), 5);
        queue_decode($urandom_range(255), 8);

        queue_random(55);
        wait_drained();

        load_root(htd_pkg::NODES - 1, 71, 27, 1);
        queue_random(30);
        // sender holds back until everything has come out
        wait_drained();
        queue_random(30);
        wait_drained();

        load_root($urandom_range(htd_pkg::NODES - 2, 1), 0, 0, 2);
        queue_random(65);
        wait_drained();

        load_root(0, 0, 0, 3);
        queue_random(45);
        wait_drained();

        repeat (SETTLE) @(posedge clk);
        if (bad_results == 0 && symbols_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // ---------------------------------------------------------------- driver

    always @(posedge clk) begin : drive_requests
        t_request nxt;
        if (!rst_n) begin
            req_valid <= 1'b0;
        end else if (!req_valid || !in_stall) begin
            if (requests_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                nxt = requests_to_send.pop_front();
                req       <= nxt;
                req_valid <= 1'b1;
            end else begin
                req_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- receiver

    always @(posedge clk) begin
        if (!rst_n) begin
            res_stall <= 1'b0;
            hold_left <= 0;
        end else if (hold_left != 0) begin
            res_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (phase_idx == 2 && !hold_done && res_valid) begin
            // long back-pressure so the decoder fills and stalls its input
            res_stall <= 1'b1;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            res_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk) begin : check_results
        t_result want;
        if (!rst_n) begin
            root_reg = '0;
            walk_pos = '0;
        end else begin
            if (cfg_we) begin
                root_reg = cfg_data;
                walk_pos = cfg_data;
            end
            if (req_valid && !in_stall)
                decode_request(req);
            if (res_valid && !res_stall) begin
                if (symbols_due.size() == 0) begin
                    $error("unexpected result: symbol %0h error %0b last %0b",
                           res_symbol, res_error, res_last);
                    bad_results++;
                end else begin
                    want = symbols_due.pop_front();
                    if (res_symbol !== want.symbol) begin
                        $error("symbol: expected %0h, actual %0h", want.symbol, res_symbol);
                        bad_results++;
                    end
                    if (res_error !== want.error) begin
                        $error("error: expected %0b, actual %0b", want.error, res_error);
                        bad_results++;
                    end
                    if (res_last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, res_last);
                        bad_results++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
